FILE: src/pfc_pkg.sv
// Package: shared constants, types and helpers for the polygon frustum clipper.
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;

  localparam int MAX_VERTS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ATTR      = 6;
  localparam int NUM_PLANES    = 4;
  localparam int WORD_W        = 32;
  localparam int VERT_W        = NUM_ATTR * WORD_W;

  typedef logic [NUM_ATTR-1:0][WORD_W-1:0] vert_t;

  typedef enum logic [1:0] {
    WS_IN,
    WS_PREV,
    WS_NV
  } wsrc_t;

  localparam logic [1:0] PL_LEFT   = 2'd0;
  localparam logic [1:0] PL_RIGHT  = 2'd1;
  localparam logic [1:0] PL_TOP    = 2'd2;
  localparam logic [1:0] PL_BOTTOM = 2'd3;

  localparam int ATTR_X = 0;
  localparam int ATTR_Y = 1;
  localparam int ATTR_Z = 2;

  typedef struct packed {
    logic       wr_en;
    wsrc_t      wr_sel;
    logic       rd_en;
    logic       lat_prev;
    logic       lat_cur;
    logic       shift_prev;
    logic       div_init;
    logic       div_step;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       acc_en;
    logic [2:0] acc_idx;
    logic [1:0] plane;
    logic       out_load;
    logic       out_empty;
    logic       out_last;
    logic       out_ovf;
  } cmd_t;

  typedef struct packed {
    logic da_neg;
    logic db_neg;
  } stat_t;

  function automatic logic [WORD_W-1:0] plane_dist(input logic [1:0] plane, input vert_t vx);
    logic [WORD_W-1:0] d;
    case (plane)
      PL_LEFT:   d = vx[ATTR_X] + vx[ATTR_Z];
      PL_RIGHT:  d = vx[ATTR_Z] - vx[ATTR_X];
      PL_TOP:    d = vx[ATTR_Y] + vx[ATTR_Z];
      PL_BOTTOM: d = vx[ATTR_Z] - vx[ATTR_Y];
      default:   d = vx[ATTR_Z] - vx[ATTR_Y];
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: src/pfc_ctrl.sv
// Controller: load, four clip passes and output sequencing.
`timescale 1ns / 1ps
`default_nettype none
module pfc_ctrl #(
  parameter int MAX_VERTS = pfc_pkg::MAX_VERTS_DEF,
  parameter int FRAC_BITS = pfc_pkg::FRAC_BITS_DEF,
  localparam int IW = $clog2(MAX_VERTS),
  localparam int AW = IW + 1
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  input  wire              in_tlast,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire              out_tready,
  input  pfc_pkg::stat_t   stat,
  output pfc_pkg::cmd_t    cmd,
  output logic [AW-1:0]    rd_addr,
  output logic [AW-1:0]    wr_addr
);

  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int BW = $clog2(FRAC_BITS + 2);
  localparam logic [CW-1:0] MAXC = CW'(MAX_VERTS);

  typedef enum logic [3:0] {
    S_LOAD, S_PSTART, S_PRIME, S_FETCH, S_EDGE, S_DIV, S_MUL, S_PUSHI,
    S_NEXT, S_PEND, S_OSTART, S_ORD, S_OHOLD
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, n_r, n_nxt, r_r, r_nxt, b_r, b_nxt, k_r, k_nxt;
  logic [1:0]      plane_r, plane_nxt;
  logic            src_r, src_nxt, ovf_r, ovf_nxt;
  logic [BW-1:0]   bit_r, bit_nxt;
  logic [2:0]      mk_r, mk_nxt;
  logic [CW-1:0]   b_inc, k_inc, n_dec;

  assign b_inc = b_r + 1'b1;
  assign k_inc = k_r + 1'b1;
  assign n_dec = n_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      r_r     <= '0;
      b_r     <= '0;
      k_r     <= '0;
      plane_r <= '0;
      src_r   <= 1'b0;
      ovf_r   <= 1'b0;
      bit_r   <= '0;
      mk_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      r_r     <= r_nxt;
      b_r     <= b_nxt;
      k_r     <= k_nxt;
      plane_r <= plane_nxt;
      src_r   <= src_nxt;
      ovf_r   <= ovf_nxt;
      bit_r   <= bit_nxt;
      mk_r    <= mk_nxt;
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OHOLD);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    plane_nxt = plane_r;
    src_nxt   = src_r;
    ovf_nxt   = ovf_r;
    bit_nxt   = bit_r;
    mk_nxt    = mk_r;
    cmd       = '0;
    cmd.wr_sel = pfc_pkg::WS_IN;
    cmd.plane = plane_r;
    cmd.out_ovf = ovf_r;
    cmd.mul_idx = mk_r;
    cmd.acc_idx = mk_r - 3'd1;
    rd_addr   = '0;
    wr_addr   = '0;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < MAXC) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = pfc_pkg::WS_IN;
            wr_addr    = {1'b0, cnt_r[IW-1:0]};
            cnt_nxt    = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt     = (cnt_r < MAXC) ? cnt_r + 1'b1 : cnt_r;
            plane_nxt = '0;
            src_nxt   = 1'b0;
            state_nxt = S_PSTART;
          end
        end
      end
      S_PSTART: begin
        r_nxt = '0;
        b_nxt = '0;
        if (n_r < CW'(3)) begin
          n_nxt     = '0;
          state_nxt = S_PEND;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = {src_r, n_dec[IW-1:0]};
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.lat_prev = 1'b1;
        cmd.rd_en    = 1'b1;
        rd_addr      = {src_r, b_r[IW-1:0]};
        state_nxt    = S_FETCH;
      end
      S_FETCH: begin
        cmd.lat_cur = 1'b1;
        state_nxt   = S_EDGE;
      end
      S_EDGE: begin
        if (!stat.da_neg) begin
          if (r_r < MAXC) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = pfc_pkg::WS_PREV;
            wr_addr    = {~src_r, r_r[IW-1:0]};
            r_nxt      = r_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (stat.da_neg != stat.db_neg) begin
          cmd.div_init = 1'b1;
          bit_nxt      = '0;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + 1'b1;
        if (bit_r == BW'(FRAC_BITS)) begin
          mk_nxt    = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = (mk_r < 3'(pfc_pkg::NUM_ATTR));
        cmd.acc_en = (mk_r != 3'd0);
        mk_nxt     = mk_r + 3'd1;
        if (mk_r == 3'(pfc_pkg::NUM_ATTR)) state_nxt = S_PUSHI;
      end
      S_PUSHI: begin
        if (r_r < MAXC) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = pfc_pkg::WS_NV;
          wr_addr    = {~src_r, r_r[IW-1:0]};
          r_nxt      = r_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.shift_prev = 1'b1;
        b_nxt          = b_inc;
        if (b_inc == n_r) begin
          state_nxt = S_PEND;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = {src_r, b_inc[IW-1:0]};
          state_nxt = S_FETCH;
        end
      end
      S_PEND: begin
        n_nxt     = r_r;
        src_nxt   = ~src_r;
        plane_nxt = plane_r + 2'd1;
        state_nxt = (plane_r == 2'(pfc_pkg::NUM_PLANES - 1)) ? S_OSTART : S_PSTART;
      end
      S_OSTART: begin
        k_nxt = '0;
        if (n_r == '0) begin
          cmd.out_load  = 1'b1;
          cmd.out_empty = 1'b1;
          cmd.out_last  = 1'b1;
          state_nxt     = S_OHOLD;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = {src_r, {IW{1'b0}}};
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (k_inc == n_r);
        state_nxt    = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_tready) begin
          if (n_r == '0 || k_inc == n_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            plane_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc;
            cmd.rd_en = 1'b1;
            rd_addr   = {src_r, k_inc[IW-1:0]};
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/pfc_dp.sv
// Datapath: vertex memory, edge registers, divider, interpolator, output register.
`timescale 1ns / 1ps
`default_nettype none
module pfc_dp #(
  parameter int MAX_VERTS = pfc_pkg::MAX_VERTS_DEF,
  parameter int FRAC_BITS = pfc_pkg::FRAC_BITS_DEF,
  localparam int IW = $clog2(MAX_VERTS),
  localparam int AW = IW + 1
) (
  input  wire                          clk,
  input  pfc_pkg::cmd_t                cmd,
  input  wire [AW-1:0]                 rd_addr,
  input  wire [AW-1:0]                 wr_addr,
  input  wire [pfc_pkg::VERT_W-1:0]    in_vert,
  output pfc_pkg::stat_t               stat,
  output logic [pfc_pkg::VERT_W-1:0]   out_vert,
  output logic                         out_last,
  output logic                         out_empty,
  output logic                         out_ovf
);

  localparam int DEPTH = 2 << IW;
  localparam int RW = 35;
  localparam int PW = FRAC_BITS + 35;

  pfc_pkg::vert_t mem [0:DEPTH-1];
  pfc_pkg::vert_t rd_q_r, prev_r, cur_r, nv_r, wdata, out_r;
  logic [31:0]    dprev_r, dcur_r, da_abs;
  logic [32:0]    den_r, dd;
  logic [RW-1:0]  rem_r, rem_sub;
  logic [FRAC_BITS:0] q_r;
  logic signed [32:0] diff;
  logic signed [PW-1:0] prod_r, stepw;
  logic           last_r, empty_r, ovf_r;

  always_comb begin
    case (cmd.wr_sel)
      pfc_pkg::WS_IN:   wdata = pfc_pkg::vert_t'(in_vert);
      pfc_pkg::WS_PREV: wdata = prev_r;
      pfc_pkg::WS_NV:   wdata = nv_r;
      default:          wdata = pfc_pkg::vert_t'(in_vert);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wdata;
    if (cmd.rd_en) rd_q_r <= mem[rd_addr];
  end

  assign da_abs  = dprev_r[31] ? (32'd0 - dprev_r) : dprev_r;
  assign dd      = {dprev_r[31], dprev_r} - {dcur_r[31], dcur_r};
  assign rem_sub = rem_r - {2'b00, den_r};
  assign diff    = $signed({cur_r[cmd.mul_idx][31], cur_r[cmd.mul_idx]})
                 - $signed({prev_r[cmd.mul_idx][31], prev_r[cmd.mul_idx]});
  assign stepw   = prod_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.lat_prev) begin
      prev_r  <= rd_q_r;
      dprev_r <= pfc_pkg::plane_dist(cmd.plane, rd_q_r);
    end
    if (cmd.lat_cur) begin
      cur_r  <= rd_q_r;
      dcur_r <= pfc_pkg::plane_dist(cmd.plane, rd_q_r);
    end
    if (cmd.shift_prev) begin
      prev_r  <= cur_r;
      dprev_r <= dcur_r;
    end
    if (cmd.div_init) begin
      rem_r <= {3'b000, da_abs};
      den_r <= dd[32] ? (33'd0 - dd) : dd;
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= {2'b00, den_r}) begin
        rem_r <= {rem_sub[RW-2:0], 1'b0};
        q_r   <= {q_r[FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_r <= {rem_r[RW-2:0], 1'b0};
        q_r   <= {q_r[FRAC_BITS-1:0], 1'b0};
      end
    end
    if (cmd.mul_en) prod_r <= diff * $signed({1'b0, q_r});
    if (cmd.acc_en) nv_r[cmd.acc_idx] <= prev_r[cmd.acc_idx] + stepw[31:0];
    if (cmd.out_load) begin
      out_r   <= cmd.out_empty ? '0 : rd_q_r;
      last_r  <= cmd.out_last;
      empty_r <= cmd.out_empty;
      ovf_r   <= cmd.out_ovf;
    end
  end

  assign stat.da_neg = dprev_r[31];
  assign stat.db_neg = dcur_r[31];
  assign out_vert    = out_r;
  assign out_last    = last_r;
  assign out_empty   = empty_r;
  assign out_ovf     = ovf_r;

endmodule
`default_nettype wire

FILE: src/polygon_frustum_clipper.sv
// Top level: polygon clipper against the four side planes of the view frustum.
// Load: one vertex per cycle. After the closing vertex, each pass walks the edges; a pass
// that gets fewer than 3 vertices yields an empty polygon. Each crossing edge adds an
// interpolated vertex (bit-serial divider, one attribute multiply per cycle).
// Output: a start step, then each vertex is read and held until taken. One polygon at a time.
// Reset (rst_n low, synchronous) clears controller counters, flags, state; memory is kept.
`timescale 1ns / 1ps
`default_nettype none
module polygon_frustum_clipper #(
  parameter int MAX_VERTS = pfc_pkg::MAX_VERTS_DEF,
  parameter int FRAC_BITS = pfc_pkg::FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire [191:0]  in_tdata,   // in_x, in_y, in_z, in_u, in_v, in_w
  input  wire          in_tlast,
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [191:0] out_tdata,  // out_x, out_y, out_z, out_u, out_v, out_w
  output logic         out_tlast,
  output logic [1:0]   out_tuser   // out_empty, out_overflow
);

  localparam int AW = $clog2(MAX_VERTS) + 1;

  pfc_pkg::cmd_t  cmd;
  pfc_pkg::stat_t stat;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           empty, ovf;

  pfc_ctrl #(.MAX_VERTS(MAX_VERTS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tlast(in_tlast), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .stat(stat), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr)
  );

  pfc_dp #(.MAX_VERTS(MAX_VERTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
    .in_vert(in_tdata), .stat(stat), .out_vert(out_tdata),
    .out_last(out_tlast), .out_empty(empty), .out_ovf(ovf)
  );

  assign out_tuser = {ovf, empty};

endmodule
`default_nettype wire
